// File: rtl/cube_face_orientation_debounce_defines.svh
// ----------------------------------------------------------------------------
// Cube face orientation debounce - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef CUBE_FACE_ORIENTATION_DEBOUNCE_DEFINES_SVH
`define CUBE_FACE_ORIENTATION_DEBOUNCE_DEFINES_SVH

// same-cycle implication
`define CFOD_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// next-cycle implication
`define CFOD_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

// File: rtl/cfod_pkg.sv
// ----------------------------------------------------------------------------
// Cube face orientation debounce - package
// Field widths, codes, beat types and constants shared by the front end, back end,
// top level and testbench.
package cfod_pkg;

  localparam int TIME_BITS   = 40;
  localparam int SAMPLE_BITS = 16;
  localparam int SEC_BITS    = 31;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam int MS_PER_S = 1000;
  localparam int MOD_STEP = 2;

  // floor(ms / 1000) = floor((ms >> 3) * DIV_RECIP / 2**DIV_SHIFT) for ms < 2**40
  localparam int DIV_PRE    = 3;
  localparam int DIV_SHIFT  = 44;
  localparam int RECIP_BITS = 38;
  localparam logic [RECIP_BITS-1:0] DIV_RECIP = 38'd140737488356;

  localparam logic [CFG_BITS-1:0] SETTLE_MS_RST    = CFG_BITS'(1500);
  localparam logic [CFG_BITS-1:0] INTERVAL_MS_RST  = CFG_BITS'(100);
  localparam logic [CFG_BITS-1:0] LOG_PERIOD_S_RST = CFG_BITS'(60);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SETTLE     = 2'd0,
    REG_INTERVAL   = 2'd1,
    REG_LOG_PERIOD = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FACE_NONE  = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_X = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Y = 3'd4,
    FACE_POS_Z = 3'd5
  } face_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_BOOT   = 2'd1,
    EV_SWITCH = 2'd2,
    EV_LOG    = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEC,
    ST_MOD,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic [TIME_BITS-1:0]          now_ms;
  } sample_t;

  typedef struct packed {
    event_kind_t         event_kind;
    logic [SEC_BITS-1:0] event_seconds;
    face_t               current_face;
    logic [SEC_BITS-1:0] session_seconds;
  } result_t;

  typedef struct packed {
    face_t                face;
    logic [TIME_BITS-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic                    write;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;
  } cfg_wr_t;

endpackage

// File: rtl/cfod_fifo.sv
// ----------------------------------------------------------------------------
// Cube face orientation debounce - queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cfod_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/cfod_front.sv
// ----------------------------------------------------------------------------
// Cube face orientation debounce - front end
// Classifies a sample into its resting face by the dominant axis.
// ----------------------------------------------------------------------------
module cfod_front (
  input  cfod_pkg::sample_t sample,
  output cfod_pkg::item_t   item
);
  import cfod_pkg::*;

  logic signed [SAMPLE_BITS:0] xe, ye, ze;
  logic [SAMPLE_BITS:0]        mx, my, mz;
  logic                        x_pos, y_pos, z_pos;
  face_t                       face;

  always_comb begin
    xe = {sample.accel_x[SAMPLE_BITS-1], sample.accel_x};
    ye = {sample.accel_y[SAMPLE_BITS-1], sample.accel_y};
    ze = {sample.accel_z[SAMPLE_BITS-1], sample.accel_z};
    mx = xe[SAMPLE_BITS] ? -xe : xe;
    my = ye[SAMPLE_BITS] ? -ye : ye;
    mz = ze[SAMPLE_BITS] ? -ze : ze;
    x_pos = !xe[SAMPLE_BITS] && (|sample.accel_x);
    y_pos = !ye[SAMPLE_BITS] && (|sample.accel_y);
    z_pos = !ze[SAMPLE_BITS] && (|sample.accel_z);
    priority if (mx > my && mx > mz) begin
      face = x_pos ? FACE_POS_X : FACE_NEG_X;
    end else if (my > mx && my > mz) begin
      face = y_pos ? FACE_POS_Y : FACE_NEG_Y;
    end else begin
      face = z_pos ? FACE_POS_Z : FACE_NONE;
    end
  end

  assign item.face   = face;
  assign item.now_ms = sample.now_ms;

endmodule

// File: rtl/cfod_back.sv
// ----------------------------------------------------------------------------
// Cube face orientation debounce - back end
// Debounce state, config registers, seconds divider and log-period check.
// ----------------------------------------------------------------------------
module cfod_back (
  input  logic              clk,
  input  logic              rst,
  input  cfod_pkg::cfg_wr_t cfg,
  input  logic              item_empty,
  input  cfod_pkg::item_t   item,
  output logic              item_pop,
  input  logic              res_full,
  output logic              res_push,
  output cfod_pkg::result_t res
);
  import cfod_pkg::*;

  localparam int HalfW     = RECIP_BITS / 2;
  localparam int AccW      = 4 * HalfW;
  localparam int DivCycles = 4;
  localparam int DivCntW   = $clog2(DivCycles + 1);
  localparam int ModW      = ((SEC_BITS + MOD_STEP - 1) / MOD_STEP) * MOD_STEP;
  localparam int ModCycles = ModW / MOD_STEP;
  localparam int ModCntW   = $clog2(ModCycles + 1);
  localparam int CntW      = (DivCntW > ModCntW) ? DivCntW : ModCntW;
  localparam logic [HalfW-1:0] RecipLo = DIV_RECIP[HalfW-1:0];
  localparam logic [HalfW-1:0] RecipHi = DIV_RECIP[RECIP_BITS-1:HalfW];

  logic [CFG_BITS-1:0]  settle_ms;
  logic [CFG_BITS-1:0]  sample_interval_ms;
  logic [CFG_BITS-1:0]  log_period_s;

  logic                 started;
  face_t                settled_face;
  face_t                candidate_face;
  logic [TIME_BITS-1:0] candidate_since_ms;
  logic [TIME_BITS-1:0] session_start_ms;
  logic [TIME_BITS-1:0] last_sample_ms;

  back_state_t          state, state_next;
  logic [CntW-1:0]      cnt;
  logic [2*HalfW-1:0]   div_y;
  logic [AccW-1:0]      div_acc, div_acc_next;
  logic [HalfW-1:0]     mul_a, mul_b;
  logic [2*HalfW-1:0]   mul_p;
  logic [AccW-1:0]      mul_term;
  logic [ModW-1:0]      mod_sh, mod_sh_next;
  logic [CFG_BITS-1:0]  mod_rem, mod_rem_next;
  logic                 log_check;
  event_kind_t          kind;

  logic                 take;
  logic                 gap_ok, new_cand, settle_ok, do_switch, do_log, back_ok;
  logic [TIME_BITS-1:0] diff;
  logic                 div_last, mod_last;
  logic [SEC_BITS-1:0]  secs, secs_next;

  // decision on the item at the head of the queue
  always_comb begin
    gap_ok    = (item.now_ms >= last_sample_ms) &&
                ((item.now_ms - last_sample_ms) >= TIME_BITS'(sample_interval_ms));
    new_cand  = (item.face != candidate_face);
    settle_ok = (candidate_face != settled_face) &&
                (item.now_ms >= candidate_since_ms) &&
                ((item.now_ms - candidate_since_ms) >= TIME_BITS'(settle_ms));
    do_switch = started && gap_ok && !new_cand && settle_ok;
    do_log    = started && gap_ok && !new_cand && !settle_ok;
    back_ok   = (item.now_ms >= session_start_ms);
    diff      = (!started || do_switch || !back_ok) ? '0
                                                    : item.now_ms - session_start_ms;
  end

  // divide by 1000 as a reciprocal multiply, one partial product per cycle
  always_comb begin
    mul_a = cnt[1] ? div_y[2*HalfW-1:HalfW] : div_y[HalfW-1:0];
    mul_b = cnt[0] ? RecipHi : RecipLo;
    mul_p = (2*HalfW)'(mul_a) * (2*HalfW)'(mul_b);
    unique case (cnt[1:0])
      2'd0:    mul_term = AccW'(mul_p);
      2'd3:    mul_term = {mul_p, {(2*HalfW){1'b0}}};
      default: mul_term = AccW'({mul_p, {HalfW{1'b0}}});
    endcase
    div_acc_next = div_acc + mul_term;
  end

  // remainder by log period, MOD_STEP bits per cycle
  always_comb begin
    logic [CFG_BITS:0] t;
    logic [CFG_BITS:0] tsub;
    mod_rem_next = mod_rem;
    mod_sh_next  = mod_sh;
    for (int i = 0; i < MOD_STEP; i++) begin
      t           = {mod_rem_next, mod_sh_next[ModW-1]};
      tsub        = t - {1'b0, log_period_s};
      mod_sh_next = {mod_sh_next[ModW-2:0], 1'b0};
      if (t >= {1'b0, log_period_s}) begin
        mod_rem_next = tsub[CFG_BITS-1:0];
      end else begin
        mod_rem_next = t[CFG_BITS-1:0];
      end
    end
  end

  assign secs      = div_acc[DIV_SHIFT +: SEC_BITS];
  assign secs_next = div_acc_next[DIV_SHIFT +: SEC_BITS];
  assign div_last  = (cnt == CntW'(DivCycles - 1));
  assign mod_last  = (cnt == CntW'(ModCycles - 1));

  // sequencer
  always_comb begin
    state_next = state;
    take       = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!item_empty) begin
          take       = 1'b1;
          state_next = ST_SEC;
        end
      end
      ST_SEC: begin
        if (div_last) begin
          if (log_check && (secs_next != '0) && (log_period_s != '0)) begin
            state_next = ST_MOD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MOD: begin
        if (mod_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign item_pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms          <= SETTLE_MS_RST;
      sample_interval_ms <= INTERVAL_MS_RST;
      log_period_s       <= LOG_PERIOD_S_RST;
    end else if (cfg.write) begin
      unique case (cfg.index)
        REG_SETTLE:     settle_ms          <= cfg.data;
        REG_INTERVAL:   sample_interval_ms <= cfg.data;
        REG_LOG_PERIOD: log_period_s       <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started            <= 1'b0;
      settled_face       <= FACE_NONE;
      candidate_face     <= FACE_NONE;
      candidate_since_ms <= '0;
      session_start_ms   <= '0;
      last_sample_ms     <= '0;
    end else if (take) begin
      if (!started) begin
        started            <= 1'b1;
        settled_face       <= item.face;
        candidate_face     <= item.face;
        candidate_since_ms <= item.now_ms;
        session_start_ms   <= item.now_ms;
        last_sample_ms     <= item.now_ms;
      end else if (gap_ok) begin
        last_sample_ms <= item.now_ms;
        if (new_cand) begin
          candidate_face     <= item.face;
          candidate_since_ms <= item.now_ms;
        end else if (do_switch) begin
          settled_face     <= candidate_face;
          session_start_ms <= item.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      log_check <= 1'b0;
      kind      <= EV_NONE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt       <= '0;
          log_check <= do_log;
          kind      <= !started ? EV_BOOT : (do_switch ? EV_SWITCH : EV_NONE);
        end
        ST_SEC: begin
          cnt <= div_last ? '0 : cnt + 1'b1;
        end
        ST_MOD: begin
          cnt <= cnt + 1'b1;
          if (mod_last && (mod_rem_next == '0)) begin
            kind <= EV_LOG;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        div_y   <= (2*HalfW)'(diff[TIME_BITS-1:DIV_PRE]);
        div_acc <= '0;
      end
      ST_SEC: begin
        div_acc <= div_acc_next;
        mod_sh  <= ModW'(secs_next);
        mod_rem <= '0;
      end
      ST_MOD: begin
        mod_sh  <= mod_sh_next;
        mod_rem <= mod_rem_next;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign res.event_kind      = kind;
  assign res.event_seconds   = (kind == EV_LOG) ? secs : '0;
  assign res.current_face    = settled_face;
  assign res.session_seconds = secs;

endmodule

// File: rtl/cube_face_orientation_debounce.sv
// ----------------------------------------------------------------------------
// Cube face orientation debounce - top level
// Flow: each accepted sample is popped from the sample queue; ST_SEC runs the
// reciprocal divide by 1000, ST_MOD the log-period remainder loop when a log
// check runs, and ST_DONE pushes the result beat once the result queue has
// room. A new sample is taken only after the last result beat is pushed.
// Reset: synchronous rst empties both queues, clears state, loads 1500/100/60.
// ----------------------------------------------------------------------------
`include "cube_face_orientation_debounce_defines.svh"

module cube_face_orientation_debounce #(
  parameter int ITEM_DEPTH   = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [cfod_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [cfod_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                 push,
  input  cfod_pkg::sample_t                    sample,
  output logic                                 full,
  input  logic                                 pop,
  output cfod_pkg::result_t                    result,
  output logic                                 empty
);
  import cfod_pkg::*;

  item_t   item_in, item_out;
  logic    item_empty, item_pop;
  result_t res;
  logic    res_push, res_full;
  cfg_wr_t cfg;
  logic    beat_log, beat_quiet, beat_restart, log_secs_ok;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  cfod_front u_front (
    .sample (sample),
    .item   (item_in)
  );

  cfod_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (ITEM_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (item_pop),
    .rdata (item_out),
    .empty (item_empty)
  );

  cfod_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_empty (item_empty),
    .item       (item_out),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  cfod_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  assign beat_log     = !empty && (result.event_kind == EV_LOG);
  assign beat_quiet   = !empty && (result.event_kind != EV_LOG);
  assign beat_restart = !empty &&
                        (result.event_kind == EV_BOOT || result.event_kind == EV_SWITCH);
  assign log_secs_ok  = (result.event_seconds == result.session_seconds) &&
                        (result.session_seconds != '0);

  `CFOD_ASSERT_IMP(a_log_seconds, beat_log, log_secs_ok, "log beat seconds mismatch")
  `CFOD_ASSERT_IMP(a_quiet_seconds, beat_quiet, result.event_seconds == '0, "stray seconds")
  `CFOD_ASSERT_IMP(a_restart, beat_restart, result.session_seconds == '0, "no restart")
  `CFOD_ASSERT_NEXT(a_item_held, push && !full, !item_empty, "accepted beat lost")

endmodule

// File: tb/sv/cfod_face_checker.sv
// ----------------------------------------------------------------------------
// Cube face orientation debounce - result checker
// Watches the register port, the sample queue and the result queue. Keeps
// its own copy of the face, candidate, session and register state, predicts
// one result beat per accepted sample and compares each popped beat with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cfod_face_checker
  import cfod_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    push,
  input  sample_t                 sample,
  input  logic                    full,
  input  logic                    pop,
  input  result_t                 result,
  input  logic                    empty,
  output int                      due_count,
  output int                      mismatches
);

  logic [CFG_BITS-1:0]  settle_len;
  logic [CFG_BITS-1:0]  min_gap;
  logic [CFG_BITS-1:0]  log_every;
  logic                 seen_first;
  face_t                held_face;
  face_t                pending_face;
  logic [TIME_BITS-1:0] pending_since;
  logic [TIME_BITS-1:0] session_t0;
  logic [TIME_BITS-1:0] last_taken;
  result_t              reports_due[$];

  initial begin
    mismatches = 0;
    due_count  = 0;
  end

  task automatic report(string msg);
    if (mismatches < 50) $display("%0t cfod check: %s", $time, msg);
    mismatches++;
  endtask

  function automatic face_t face_of(sample_t s);
    int ax, ay, az;
    ax = (s.accel_x < 0) ? -int'(s.accel_x) : int'(s.accel_x);
    ay = (s.accel_y < 0) ? -int'(s.accel_y) : int'(s.accel_y);
    az = (s.accel_z < 0) ? -int'(s.accel_z) : int'(s.accel_z);
    if (ax > ay && ax > az) return (s.accel_x > 0) ? FACE_POS_X : FACE_NEG_X;
    if (ay > ax && ay > az) return (s.accel_y > 0) ? FACE_POS_Y : FACE_NEG_Y;
    return (s.accel_z > 0) ? FACE_POS_Z : FACE_NONE;
  endfunction

  function automatic logic [SEC_BITS-1:0] secs_since(logic [TIME_BITS-1:0] t);
    logic [TIME_BITS-1:0] whole;
    if (t < session_t0) return '0;
    whole = (t - session_t0) / MS_PER_S;
    return whole[SEC_BITS-1:0];
  endfunction

  task automatic track_sample(sample_t s);
    face_t               f;
    result_t             r;
    logic [SEC_BITS-1:0] secs;
    f = face_of(s);
    r.event_kind    = EV_NONE;
    r.event_seconds = '0;
    if (!seen_first) begin
      seen_first    = 1'b1;
      held_face     = f;
      pending_face  = f;
      pending_since = s.now_ms;
      session_t0    = s.now_ms;
      last_taken    = s.now_ms;
      r.event_kind  = EV_BOOT;
    end else if (s.now_ms >= last_taken && s.now_ms - last_taken >= min_gap) begin
      last_taken = s.now_ms;
      if (f != pending_face) begin
        pending_face  = f;
        pending_since = s.now_ms;
      end else if (pending_face != held_face && s.now_ms >= pending_since &&
                   s.now_ms - pending_since >= settle_len) begin
        held_face    = pending_face;
        session_t0   = s.now_ms;
        r.event_kind = EV_SWITCH;
      end else begin
        secs = secs_since(s.now_ms);
        if (secs != 0 && log_every != 0 && secs % log_every == 0) begin
          r.event_kind    = EV_LOG;
          r.event_seconds = secs;
        end
      end
    end
    r.current_face    = held_face;
    r.session_seconds = secs_since(s.now_ms);
    reports_due.push_back(r);
  endtask

  task automatic check_beat(result_t got);
    result_t want;
    if (reports_due.size() == 0) begin
      report("result beat with no sample pending");
      return;
    end
    want = reports_due.pop_front();
    if (got.event_kind !== want.event_kind)
      report($sformatf("event_kind %0d, want %0d", got.event_kind, want.event_kind));
    if (got.event_seconds !== want.event_seconds)
      report($sformatf("event_seconds %0d, want %0d", got.event_seconds,
                       want.event_seconds));
    if (got.current_face !== want.current_face)
      report($sformatf("current_face %0d, want %0d", got.current_face,
                       want.current_face));
    if (got.session_seconds !== want.session_seconds)
      report($sformatf("session_seconds %0d, want %0d", got.session_seconds,
                       want.session_seconds));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settle_len    = SETTLE_MS_RST;
      min_gap       = INTERVAL_MS_RST;
      log_every     = LOG_PERIOD_S_RST;
      seen_first    = 1'b0;
      held_face     = FACE_NONE;
      pending_face  = FACE_NONE;
      pending_since = '0;
      session_t0    = '0;
      last_taken    = '0;
      reports_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_SETTLE:     settle_len = cfg_data;
          REG_INTERVAL:   min_gap    = cfg_data;
          REG_LOG_PERIOD: log_every  = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) check_beat(result);
      if (push && !full) track_sample(sample);
    end
    due_count <= reports_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Cube face orientation debounce - testbench top
// Drives directed samples covering every event kind, face and tie case, then
// six register settings with random pose runs, time steps that are ignored,
// exact, backward or jumping, and random noise. Both queue sides stall at
// random; one long result-side hold fills the block. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import cfod_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 313;
  localparam int JUMP_MAX_MS  = 20_000_000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    push = 1'b0;
  sample_t                 sample = '0;
  logic                    full;
  logic                    pop = 1'b0;
  result_t                 result;
  logic                    empty;
  int                      due_count;
  int                      mismatches;

  int   cycle_count = 0;
  int   offer_idle_pct = 20;
  int   take_idle_pct = 66;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   gap_ms = 100;

  cube_face_orientation_debounce dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty)
  );

  cfod_face_checker face_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .sample     (sample),
    .full       (full),
    .pop        (pop),
    .result     (result),
    .empty      (empty),
    .due_count  (due_count),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_go) begin
      pop       <= 1'b0;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  function automatic sample_t raw_sample(int x, int y, int z, logic [TIME_BITS-1:0] t);
    sample_t s;
    s.accel_x = 16'(x);
    s.accel_y = 16'(y);
    s.accel_z = 16'(z);
    s.now_ms  = t;
    return s;
  endfunction

  // dominant axis with sign; a tie leaves the face to the sign of z
  function automatic sample_t posed_sample(int axis, bit neg, bit tie,
                                           logic [TIME_BITS-1:0] t);
    int mag, other;
    int v[3];
    mag = neg ? $urandom_range(32768, 1) : $urandom_range(32767, 1);
    for (int i = 0; i < 3; i++) begin
      v[i] = $urandom_range(mag - 1, 0);
      if ($urandom_range(1)) v[i] = -v[i];
    end
    v[axis] = neg ? -mag : mag;
    if (tie) begin
      other = (axis == 0) ? 1 : 0;
      v[other] = (mag == 32768 || $urandom_range(1)) ? -mag : mag;
      if (axis != 2)
        v[2] = neg ? -$urandom_range(mag - 1, 0) : $urandom_range(mag, 1);
    end
    return raw_sample(v[0], v[1], v[2], t);
  endfunction

  task automatic offer(sample_t s);
    while ($urandom_range(99) < offer_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    sample <= s;
    do @(posedge clk); while (full);
  endtask

  task automatic drain;
    push <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  task automatic program_regs(int settle, int gap, int period);
    cfg_write <= 1'b1;
    cfg_index <= REG_SETTLE;
    cfg_data  <= CFG_BITS'(settle);
    @(posedge clk);
    cfg_index <= REG_INTERVAL;
    cfg_data  <= CFG_BITS'(gap);
    @(posedge clk);
    cfg_index <= REG_LOG_PERIOD;
    cfg_data  <= CFG_BITS'(period);
    @(posedge clk);
    cfg_write <= 1'b0;
    gap_ms = gap;
  endtask

  initial begin
    int                   settle, period, roll, run_left, pose_axis;
    bit                   pose_neg, pose_tie;
    logic [TIME_BITS-1:0] wall, base, t;
    sample_t              s;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: 1500 ms settle, 100 ms spacing, 60 s log period
    offer(raw_sample(32767, 0, 0, 40'd0));
    offer(raw_sample(-32768, 0, 0, 40'd50));
    offer(raw_sample(-32768, 0, 0, 40'd150));
    offer(raw_sample(-32768, 1, -1, 40'd1600));
    offer(raw_sample(-1000, 999, 999, 40'd1650));
    offer(raw_sample(-1000, 999, -999, 40'd1700));
    offer(raw_sample(-32768, 0, 0, 40'd1650));
    offer(raw_sample(0, 32767, 0, 40'd1800));
    offer(raw_sample(0, -32768, 0, 40'd1900));
    offer(raw_sample(0, 0, 32767, 40'd2000));
    offer(raw_sample(0, 0, -32768, 40'd2100));
    offer(raw_sample(0, 0, 0, 40'd2200));
    offer(raw_sample(500, -500, 7, 40'd2300));
    offer(raw_sample(-500, 500, -7, 40'd2400));
    offer(raw_sample(32767, -32767, 32767, 40'd2500));
    offer(raw_sample(-32768, -32768, -32768, 40'd2600));
    offer(raw_sample(-20000, 3, 3, 40'd2700));
    offer(raw_sample(-20000, 3, 3, 40'd61700));
    offer(raw_sample(-20000, 3, 3, 40'd62699));
    offer(raw_sample(-20000, 3, 3, 40'd62700));
    offer(raw_sample(-20000, 3, 3, 40'd122700));
    offer(raw_sample(-20000, -3, 3, 40'd123700));
    drain();

    wall     = 40'd123700;
    run_left = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin settle = 0;     gap_ms = 0;     period = 1;     base = '0; end
        1: begin settle = 65535; gap_ms = 65535; period = 65535; base = 40'h12_3456_0000; end
        2: begin settle = 300;   gap_ms = 20;    period = 3;     base = 40'h55_5555_0000; end
        3: begin settle = 200;   gap_ms = 50;    period = 0;     base = 40'h7F_FFF0_0000; end
        4: begin
          settle = $urandom_range(3000);
          gap_ms = $urandom_range(300);
          period = $urandom_range(10, 1);
          base   = 40'hAA_AA00_0000;
        end
        default: begin
          settle = 1500; gap_ms = 100; period = 60; base = 40'hFF_0000_0000;
        end
      endcase
      offer_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 66 : 0;
      take_idle_pct <= (phase < 2) ? 66 : (phase < 4) ? 20 : 0;
      program_regs(settle, gap_ms, period);
      if (phase == 0) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      if (wall < base) wall = base;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          pose_axis = $urandom_range(2);
          pose_neg  = 1'($urandom_range(1));
          pose_tie  = ($urandom_range(7) == 0);
          run_left  = $urandom_range(20, 1);
        end
        run_left--;
        roll = $urandom_range(99);
        if (roll < 6) begin
          t = (wall > 40'd5000) ? wall - $urandom_range(5000, 1) : wall;
        end else begin
          if (roll < 14)
            t = wall + ((gap_ms == 0) ? 0 : $urandom_range(gap_ms - 1));
          else if (roll < 16)
            t = wall + $urandom_range(JUMP_MAX_MS);
          else if (roll < 24)
            t = wall + gap_ms;
          else
            t = wall + gap_ms + $urandom_range(gap_ms / 2 + 50);
          wall = t;
        end
        if ($urandom_range(99) < 15)
          s = raw_sample($urandom, $urandom, $urandom, t);
        else
          s = posed_sample(pose_axis, pose_neg, pose_tie, t);
        offer(s);
      end
      if (phase == 5) offer(posed_sample(pose_axis, pose_neg, pose_tie, '1));
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
